/* design/fdl_pkg.sv */
// ----------------------------------------------------------------------------
// fdl_pkg
// shared types and constants of the fractional delay line
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int STORE_DEPTH   = 4096;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int MAX_DELAY     = 4088;
  localparam int ONE_Q16       = 65536;
  localparam int MIN_DELAY_Q16 = 2 * ONE_Q16;
  localparam int MAX_DELAY_Q16 = MAX_DELAY * ONE_Q16;
  localparam int DELAY_W       = 28;
  localparam int STEPS_W       = 16;
  localparam int INC_W         = 29;
  localparam int SAMPLE_W      = 24;
  localparam int SAMPLE_MAX    = 8388607;
  localparam int SAMPLE_MIN    = -8388608;
  // ceil(2^27 / 3), exact floor(n / 3) for n below 2^27
  localparam int DIV3_RECIP    = (2 ** 27 + 1) / 3;
  localparam int RND_THIRD     = 3 * (2 ** 26);
  localparam int RND_HALF      = 2 ** 26;
  localparam int RND_OUT       = 2 ** 21;

  typedef enum logic [1:0] {
    CFG_TARGET     = 2'd0,
    CFG_RAMP_STEPS = 2'd1,
    CFG_APPLY_NOW  = 2'd2,
    CFG_INVERT     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ENG_CLEAR,
    ENG_IDLE,
    ENG_RUN,
    ENG_OUT
  } eng_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_t;

  typedef struct packed {
    logic [DELAY_W-1:0] cur_delay;
    logic               invert;
    logic               busy;
  } delay_stat_t;

endpackage

/* design/fdl_front.sv */
// ----------------------------------------------------------------------------
// fdl_front
// input side: takes frames and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module fdl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fdl_pkg::in_t   in_data_i,
  input  logic           clearing_i,
  output logic           q_valid_o,
  output fdl_pkg::in_t   q_data_o,
  input  logic           q_pop_i
);

  fdl_pkg::in_t slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         push;

  assign in_stall_o = (cnt_q == 2'd2) || clearing_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ (q_pop_i && q_valid_o);
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

/* design/fdl_ramp_div.sv */
// ----------------------------------------------------------------------------
// fdl_ramp_div
// restoring divider for the ramp increment, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fdl_ramp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              cancel_i,
  input  logic [fdl_pkg::DELAY_W-1:0]       mag_i,
  input  logic                              neg_i,
  input  logic [fdl_pkg::STEPS_W-1:0]       div_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [fdl_pkg::INC_W-1:0]  quo_o
);

  localparam int CNT_W = $clog2(fdl_pkg::DELAY_W);

  logic                          busy_q, busy_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [fdl_pkg::STEPS_W-1:0]   rem_q, rem_d, d_q;
  logic [fdl_pkg::DELAY_W-1:0]   quo_q, quo_d;
  logic                          neg_q;
  logic [fdl_pkg::STEPS_W:0]     trial;
  logic                          ge;

  always_comb begin
    trial  = {rem_q, quo_q[fdl_pkg::DELAY_W-1]};
    ge     = trial >= {1'b0, d_q};
    rem_d  = ge ? fdl_pkg::STEPS_W'(trial - {1'b0, d_q}) : trial[fdl_pkg::STEPS_W-1:0];
    quo_d  = {quo_q[fdl_pkg::DELAY_W-2:0], ge};
    done_o = busy_q && (cnt_q == CNT_W'(fdl_pkg::DELAY_W - 1));
    quo_o  = neg_q ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
    busy_d = busy_q && !done_o;
    cnt_d  = cnt_q + CNT_W'(1);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (cancel_i) begin
      busy_d = 1'b0;
    end
  end

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_i;
      d_q   <= div_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

/* design/fdl_delay_ctrl.sv */
// ----------------------------------------------------------------------------
// fdl_delay_ctrl
// configuration registers, current delay and its linear ramp
// ----------------------------------------------------------------------------
module fdl_delay_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [fdl_pkg::DELAY_W-1:0]    cfg_data_i,
  input  logic                           adv_i,
  output fdl_pkg::delay_stat_t           stat_o
);

  logic [fdl_pkg::DELAY_W-1:0]       tgt_q, tgt_d, cur_q, cur_d, clamped;
  logic [fdl_pkg::STEPS_W-1:0]       steps_q, steps_d, rem_q, rem_d;
  logic signed [fdl_pkg::INC_W-1:0]  inc_q, inc_d, quo;
  logic                              apply_q, apply_d, inv_q, inv_d;
  logic signed [fdl_pkg::INC_W-1:0]  diff;
  logic                              div_start, div_cancel, div_busy, div_done;
  fdl_pkg::cfg_idx_e                 idx;

  assign idx = fdl_pkg::cfg_idx_e'(cfg_idx_i);

  always_comb begin
    clamped = cfg_data_i;
    if (cfg_data_i < fdl_pkg::DELAY_W'(fdl_pkg::MIN_DELAY_Q16)) begin
      clamped = fdl_pkg::DELAY_W'(fdl_pkg::MIN_DELAY_Q16);
    end else if (cfg_data_i > fdl_pkg::DELAY_W'(fdl_pkg::MAX_DELAY_Q16)) begin
      clamped = fdl_pkg::DELAY_W'(fdl_pkg::MAX_DELAY_Q16);
    end
    diff = $signed({1'b0, clamped}) - $signed({1'b0, cur_q});
  end

  always_comb begin
    tgt_d      = tgt_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    rem_d      = rem_q;
    inc_d      = inc_q;
    apply_d    = apply_q;
    inv_d      = inv_q;
    div_start  = 1'b0;
    div_cancel = 1'b0;
    if (div_done) begin
      inc_d = quo;
    end
    if (adv_i && (rem_q != '0)) begin
      rem_d = rem_q - fdl_pkg::STEPS_W'(1);
      if (rem_q != fdl_pkg::STEPS_W'(1)) begin
        cur_d = fdl_pkg::DELAY_W'($signed({1'b0, cur_q}) + inc_q);
      end else begin
        cur_d = tgt_q;
      end
    end
    if (cfg_we_i) begin
      unique case (idx)
        fdl_pkg::CFG_TARGET: begin
          if (apply_q || ((clamped != tgt_q) && (steps_q == '0))) begin
            tgt_d      = clamped;
            cur_d      = clamped;
            rem_d      = '0;
            inc_d      = '0;
            div_cancel = 1'b1;
          end else if (clamped != tgt_q) begin
            tgt_d     = clamped;
            rem_d     = steps_q;
            div_start = 1'b1;
          end
        end
        fdl_pkg::CFG_RAMP_STEPS: steps_d = cfg_data_i[fdl_pkg::STEPS_W-1:0];
        fdl_pkg::CFG_APPLY_NOW:  apply_d = cfg_data_i[0];
        fdl_pkg::CFG_INVERT:     inv_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  fdl_ramp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .cancel_i (div_cancel),
    .mag_i    (fdl_pkg::DELAY_W'(diff[fdl_pkg::INC_W-1] ? -diff : diff)),
    .neg_i    (diff[fdl_pkg::INC_W-1]),
    .div_i    (steps_q),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .quo_o    (quo)
  );

  assign stat_o = '{cur_delay: cur_q, invert: inv_q, busy: div_busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q   <= fdl_pkg::DELAY_W'(fdl_pkg::MIN_DELAY_Q16);
      cur_q   <= fdl_pkg::DELAY_W'(fdl_pkg::MIN_DELAY_Q16);
      steps_q <= fdl_pkg::STEPS_W'(960);
      rem_q   <= '0;
      inc_q   <= '0;
      apply_q <= 1'b0;
      inv_q   <= 1'b0;
    end else begin
      tgt_q   <= tgt_d;
      cur_q   <= cur_d;
      steps_q <= steps_d;
      rem_q   <= rem_d;
      inc_q   <= inc_d;
      apply_q <= apply_d;
      inv_q   <= inv_d;
    end
  end

endmodule

/* design/fdl_engine.sv */
// ----------------------------------------------------------------------------
// fdl_engine
// sample stores, lagrange coefficients, multiply-accumulate and output register
// ----------------------------------------------------------------------------
module fdl_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  fdl_pkg::in_t           q_data_i,
  output logic                   q_pop_o,
  output logic                   clearing_o,
  input  fdl_pkg::delay_stat_t   stat_i,
  output logic                   adv_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output fdl_pkg::out_t          out_data_o
);

  localparam int AW = fdl_pkg::ADDR_W;

  fdl_pkg::eng_state_e state_q, state_d;
  logic [AW:0]         clr_q;
  logic [3:0]          step_q;
  logic [AW-1:0]       wi_q;
  logic                out_valid_q;
  fdl_pkg::out_t       out_q;

  logic [fdl_pkg::SAMPLE_W-1:0] mem_l [fdl_pkg::STORE_DEPTH];
  logic [fdl_pkg::SAMPLE_W-1:0] mem_r [fdl_pkg::STORE_DEPTH];
  logic [fdl_pkg::SAMPLE_W-1:0] rd_l_q, rd_r_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr, rd_addr;
  fdl_pkg::in_t                 mem_wdata;

  logic                 load_out, run_last;
  logic [15:0]          frac, x16;
  logic [AW:0]          back;
  logic signed [17:0]   xs, p0, m1;
  logic signed [18:0]   m2;
  logic signed [17:0]   x_q, p0_q, m1_q;
  logic signed [18:0]   m2_q;
  logic signed [35:0]   a_q, b_q;
  logic signed [55:0]   pb_q, pc_q, pa_q, pn_q;
  logic [55:0]          mb, mc, ma, mn;
  logic [25:0]          nb_q, nc_q, na_q, nn_q;
  logic                 sb_q, sc_q, sa_q, sn_q;
  logic [51:0]          qb_full, qn_full;
  logic signed [26:0]   coef_q [4];
  logic signed [fdl_pkg::SAMPLE_W-1:0] tap_l_q [4];
  logic signed [fdl_pkg::SAMPLE_W-1:0] tap_r_q [4];
  logic signed [52:0]   acc_l_q, acc_r_q, prod_l, prod_r;
  logic signed [31:0]   y_l_q, y_r_q, y_l, y_r;

  function automatic logic signed [31:0] round_out(input logic signed [52:0] acc,
                                                   input logic inv);
    logic [52:0]        mag;
    logic [30:0]        q;
    logic signed [31:0] y;
    mag = acc[52] ? 53'(-acc) : 53'(acc);
    q   = 31'((mag + 53'(fdl_pkg::RND_OUT)) >> 22);
    y   = acc[52] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return (inv ? -y : y);
  endfunction

  function automatic logic [fdl_pkg::SAMPLE_W-1:0] sat24(input logic signed [31:0] y);
    logic [fdl_pkg::SAMPLE_W-1:0] r;
    if (y > 32'sd8388607) begin
      r = fdl_pkg::SAMPLE_W'(fdl_pkg::SAMPLE_MAX);
    end else if (y < -32'sd8388608) begin
      r = fdl_pkg::SAMPLE_W'(fdl_pkg::SAMPLE_MIN);
    end else begin
      r = y[fdl_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // read position from the current delay
  always_comb begin
    frac    = stat_i.cur_delay[15:0];
    back    = {1'b0, stat_i.cur_delay[fdl_pkg::DELAY_W-1:16]} + {{AW{1'b0}}, frac != 16'd0};
    rd_addr = wi_q - back[AW-1:0] + {{(AW-2){1'b0}}, step_q[1:0]} - AW'(1);
    x16     = ~frac + 16'd1;
    xs      = $signed({2'b00, x16});
    p0      = xs + 18'sd65536;
    m1      = xs - 18'sd65536;
    m2      = $signed({3'b000, x16}) - 19'sd131072;
    mb      = pb_q[55] ? 56'(-pb_q) : 56'(pb_q);
    mc      = pc_q[55] ? 56'(-pc_q) : 56'(pc_q);
    ma      = pa_q[55] ? 56'(-pa_q) : 56'(pa_q);
    mn      = pn_q[55] ? 56'(-pn_q) : 56'(pn_q);
    qb_full = 52'(nb_q) * 52'(fdl_pkg::DIV3_RECIP);
    qn_full = 52'(nn_q) * 52'(fdl_pkg::DIV3_RECIP);
    prod_l  = tap_l_q[step_q[1:0]] * coef_q[step_q[1:0]];
    prod_r  = tap_r_q[step_q[1:0]] * coef_q[step_q[1:0]];
    y_l     = round_out(acc_l_q, stat_i.invert);
    y_r     = round_out(acc_r_q, stat_i.invert);
  end

  assign run_last = (step_q == 4'd8);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdl_pkg::ENG_CLEAR: if (clr_q == (AW+1)'(fdl_pkg::STORE_DEPTH - 1)) begin
        state_d = fdl_pkg::ENG_IDLE;
      end
      fdl_pkg::ENG_IDLE: if (q_valid_i && !stat_i.busy) begin
        state_d = fdl_pkg::ENG_RUN;
      end
      fdl_pkg::ENG_RUN: if (run_last) begin
        state_d = fdl_pkg::ENG_OUT;
      end
      fdl_pkg::ENG_OUT: if (!out_valid_q || !out_stall_i) begin
        state_d = fdl_pkg::ENG_IDLE;
      end
      default: state_d = fdl_pkg::ENG_CLEAR;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    adv_o      = 1'b0;
    clearing_o = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wi_q;
    mem_wdata  = q_data_i;
    unique case (state_q)
      fdl_pkg::ENG_CLEAR: begin
        clearing_o = 1'b1;
        mem_we     = 1'b1;
        mem_waddr  = clr_q[AW-1:0];
        mem_wdata  = '0;
      end
      fdl_pkg::ENG_IDLE: begin
        if (q_valid_i && !stat_i.busy) begin
          q_pop_o = 1'b1;
          adv_o   = 1'b1;
          mem_we  = 1'b1;
        end
      end
      fdl_pkg::ENG_RUN: ;
      fdl_pkg::ENG_OUT: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdl_pkg::ENG_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      wi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fdl_pkg::ENG_CLEAR) begin
        clr_q <= clr_q + (AW+1)'(1);
      end
      if (state_q == fdl_pkg::ENG_RUN) begin
        step_q <= run_last ? 4'd0 : step_q + 4'd1;
        if (run_last) begin
          wi_q <= wi_q + AW'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample stores, one per channel
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_l[mem_waddr] <= mem_wdata.in_left;
      mem_r[mem_waddr] <= mem_wdata.in_right;
    end
    rd_l_q <= mem_l[rd_addr];
    rd_r_q <= mem_r[rd_addr];
  end

  // coefficient pipeline and mac, sequenced by step
  always_ff @(posedge clk_i) begin
    if (state_q == fdl_pkg::ENG_RUN) begin
      case (step_q)
        4'd0: begin
          x_q  <= xs;
          p0_q <= p0;
          m1_q <= m1;
          m2_q <= m2;
          a_q  <= xs * m1;
          b_q  <= p0 * m2;
        end
        4'd1: begin
          pb_q <= a_q * m2_q;
          pc_q <= b_q * m1_q;
          pa_q <= b_q * x_q;
          pn_q <= a_q * p0_q;
        end
        4'd2: begin
          nb_q <= 26'((mb + 56'(fdl_pkg::RND_THIRD)) >> 27);
          nc_q <= 26'((mc + 56'(fdl_pkg::RND_HALF)) >> 27);
          na_q <= 26'((ma + 56'(fdl_pkg::RND_HALF)) >> 27);
          nn_q <= 26'((mn + 56'(fdl_pkg::RND_THIRD)) >> 27);
          sb_q <= ~pb_q[55];
          sc_q <= pc_q[55];
          sa_q <= ~pa_q[55];
          sn_q <= pn_q[55];
        end
        4'd3: begin
          coef_q[0] <= sb_q ? -$signed({2'b00, qb_full[51:27]})
                            : $signed({2'b00, qb_full[51:27]});
          coef_q[1] <= sc_q ? -$signed({1'b0, nc_q}) : $signed({1'b0, nc_q});
          coef_q[2] <= sa_q ? -$signed({1'b0, na_q}) : $signed({1'b0, na_q});
          coef_q[3] <= sn_q ? -$signed({2'b00, qn_full[51:27]})
                            : $signed({2'b00, qn_full[51:27]});
        end
        4'd4: begin
          acc_l_q <= prod_l;
          acc_r_q <= prod_r;
        end
        4'd5, 4'd6, 4'd7: begin
          acc_l_q <= acc_l_q + prod_l;
          acc_r_q <= acc_r_q + prod_r;
        end
        4'd8: begin
          y_l_q <= y_l;
          y_r_q <= y_r;
        end
        default: ;
      endcase
      if ((step_q >= 4'd1) && (step_q <= 4'd4)) begin
        tap_l_q[2'(step_q - 4'd1)] <= $signed(rd_l_q);
        tap_r_q[2'(step_q - 4'd1)] <= $signed(rd_r_q);
      end
    end
    if (load_out) begin
      out_q.out_left  <= sat24(y_l_q);
      out_q.out_right <= sat24(y_r_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/fractional_delay_lagrange_core.sv */
// a frame is popped in the idle state, then runs the sequenced coefficient and mac steps
// and reaches the output register; frames do not overlap, the next is taken only after that
// a target write that starts a ramp holds frames back while the increment divider is busy
// reset: async active low; a clearing pass zeroes both sample stores,
// and no frame is taken until it ends
// ----------------------------------------------------------------------------
// fractional_delay_lagrange_core
// stereo fractional delay line with third-order lagrange interpolation
// ----------------------------------------------------------------------------
module fractional_delay_lagrange_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input frames
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fdl_pkg::in_t                in_data_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fdl_pkg::out_t               out_data_o,
  // register writes
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [fdl_pkg::DELAY_W-1:0] cfg_data_i
);

  // queue between front and engine
  logic                  q_valid, q_pop, clearing, adv;
  fdl_pkg::in_t          q_data;
  fdl_pkg::delay_stat_t  stat;

  // front: transaction acceptance and buffering
  fdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .clearing_i (clearing),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  // delay state, ramp and register file
  fdl_delay_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .stat_o     (stat)
  );

  // back end: stores, interpolation, output register
  fdl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .stat_i      (stat),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // no frame taken while the stores are being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o) else $error("frame accepted during clearing pass");

  // the delay advances only once the ramp increment is settled
  a_pop_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!stat.busy && q_valid)) else $error("frame started with divider busy");

  // delay advance and queue pop go together
  a_adv_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> q_pop) else $error("delay advanced without a frame");
`endif

endmodule
